### hdl/pedal_status_message_scheduler_unit_assert.svh
// Assertion macros shared by the pedal status scheduler checkers.
// No dependencies; included by the checker module file.
`ifndef PEDAL_STATUS_MESSAGE_SCHEDULER_UNIT_ASSERT_SVH
`define PEDAL_STATUS_MESSAGE_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PSMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PSMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/psms_pkg.sv
// Package for the pedal status message scheduler: widths, beat layout,
// register indexes, reset values, frame type and the saturating increment.
// No dependencies.
`default_nettype none

package psms_pkg;

    // Field widths
    localparam int TIMER_W    = 16;
    localparam int REPEAT_W   = 3;
    localparam int FRAME_ID_W = 11;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 10;
    localparam int LEN_W      = 2;
    localparam int FREE_W     = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Input beat layout, lowest bit first
    localparam int IN_TICK_LSB   = 0;
    localparam int IN_RXID_LSB   = 1;
    localparam int IN_RXBYTE_LSB = 12;
    localparam int IN_PARK_LSB   = 20;
    localparam int IN_BRAKE_LSB  = 21;
    localparam int IN_SAMPLE_LSB = 22;
    localparam int IN_FREE_LSB   = 32;
    localparam int IN_TDATA_W    = 40;
    localparam int IN_TUSER_W    = 2;
    localparam int IN_USER_RXV   = 0;
    localparam int IN_USER_SMPV  = 1;

    // Output beat layout, lowest bit first
    localparam int OUT_ID_LSB   = 0;
    localparam int OUT_LEN_LSB  = 11;
    localparam int OUT_PAY_LSB  = 13;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // Frame lengths
    localparam logic [LEN_W-1:0] LEN_STATE = 2'd1;
    localparam logic [LEN_W-1:0] LEN_ACCEL = 2'd2;

    // Register reset values
    localparam logic [TIMER_W-1:0]    RST_PARK_PERIOD  = 16'd100;
    localparam logic [TIMER_W-1:0]    RST_BRAKE_PERIOD = 16'd100;
    localparam logic [TIMER_W-1:0]    RST_ACCEL_PERIOD = 16'd20;
    localparam logic [REPEAT_W-1:0]   RST_REPEAT_LIMIT = 3'd5;
    localparam logic [FRAME_ID_W-1:0] RST_FRAME_ID     = 11'd0;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PARK_PERIOD,
        REG_BRAKE_PERIOD,
        REG_ACCEL_PERIOD,
        REG_PARK_REPEAT,
        REG_PARK_ACK_ID,
        REG_PARK_ID,
        REG_BRAKE_ID,
        REG_ACCEL_ID
    } cfg_reg_t;

    // One outgoing frame
    typedef struct packed {
        logic [FRAME_ID_W-1:0] frame_id;
        logic [LEN_W-1:0]      frame_len;
        logic [POS_W-1:0]      frame_payload;
        logic                  last_frame;
    } frame_t;

    // Saturating ms count
    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
        return (t == TIMER_MAX) ? TIMER_MAX : t + 1'b1;
    endfunction

endpackage

`default_nettype wire

### hdl/pedal_status_message_scheduler_unit.sv
// Pedal status message scheduler: one work-loop pass per input beat,
// up to three frames per pass. Depends on psms_pkg.
//
// Usage:
//   s_ channel: one beat per pass. s_tdata holds ms_tick, rx_frame_id,
//   rx_first_byte, park_level, brake_level, accel_sample, tx_free;
//   s_tuser holds rx_valid and sample_valid.
//   m_ channel: one beat per frame (frame_id, frame_len, frame_payload),
//   in the order park, brake, accelerator; m_tlast marks the last frame
//   of a pass. A pass that sends nothing produces no beat.
//   cfg channel: register index and data, always ready; write only while
//   the block is idle.
// Path: an accepted beat is held in the input register, then its frames
//   are loaded into the three-slot frame buffer that drives the m_ channel.
// Throughput: while m_tready is high, one pass per cycle while passes send
//   at most one frame; a pass with more frames holds the frame buffer until
//   its last frame is taken, as the buffer drains one frame per cycle on m_.
// Reset: synchronous, active low; clears timers, latched states, repeat
//   count, buffers, and loads the register defaults.
// Stall: with m_tready low the head frame holds; one more pass waits in
//   the input register, then s_tready drops.
`default_nettype none

module pedal_status_message_scheduler_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // ms_tick, rx_frame_id, rx_first_byte, park_level, brake_level,
    // accel_sample, tx_free, zero pad
    input  logic [psms_pkg::IN_TDATA_W-1:0]    s_tdata,
    // rx_valid, sample_valid
    input  logic [psms_pkg::IN_TUSER_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // frame_id, frame_len, frame_payload, zero pad
    output logic [psms_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psms_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import psms_pkg::*;

    // Configuration registers
    logic [TIMER_W-1:0]    park_period_reg, brake_period_reg, accel_period_reg;
    logic [REPEAT_W-1:0]   repeat_limit_reg;
    logic [FRAME_ID_W-1:0] ack_id_reg, park_id_reg, brake_id_reg, accel_id_reg;

    // Scheduler state
    logic                  park_state_reg, park_state_next;
    logic                  brake_state_reg, brake_state_next;
    logic [POS_W-1:0]      accel_pos_reg, accel_pos_next;
    logic [REPEAT_W-1:0]   repeats_reg, repeats_next;
    logic [TIMER_W-1:0]    park_timer_reg, park_timer_next;
    logic [TIMER_W-1:0]    brake_timer_reg, brake_timer_next;
    logic [TIMER_W-1:0]    accel_timer_reg, accel_timer_next;

    // Input register
    logic                  in_vld_reg;
    logic [IN_TDATA_W-1:0] in_data_reg;
    logic [IN_TUSER_W-1:0] in_user_reg;

    // Frame buffer, slot 0 is the head
    logic   slot_vld_reg [3];
    logic   slot_vld_next [3];
    frame_t slot_reg [3];
    frame_t slot_next [3];

    // Pass decode
    logic                  tick, rx_valid, park_level, brake_level, sample_valid;
    logic [FRAME_ID_W-1:0] rx_id;
    logic [BYTE_W-1:0]     rx_byte;
    logic [POS_W-1:0]      sample;
    logic [FREE_W-1:0]     tx_free;

    logic                  take, room, fire;
    logic                  ack, park_chg, brake_chg;
    logic [REPEAT_W-1:0]   rep_mid;
    logic [TIMER_W-1:0]    pt_mid, bt_mid, at_mid;
    logic [POS_W-1:0]      pos_mid;
    logic                  park_send, brake_send, accel_send;
    logic                  send [3];
    frame_t                cand [3];
    logic                  new_vld [3];
    frame_t                new_slot [3];

    assign tick         = in_data_reg[IN_TICK_LSB];
    assign rx_id        = in_data_reg[IN_RXID_LSB +: FRAME_ID_W];
    assign rx_byte      = in_data_reg[IN_RXBYTE_LSB +: BYTE_W];
    assign park_level   = in_data_reg[IN_PARK_LSB];
    assign brake_level  = in_data_reg[IN_BRAKE_LSB];
    assign sample       = in_data_reg[IN_SAMPLE_LSB +: POS_W];
    assign tx_free      = in_data_reg[IN_FREE_LSB +: FREE_W];
    assign rx_valid     = in_user_reg[IN_USER_RXV];
    assign sample_valid = in_user_reg[IN_USER_SMPV];

    // Handshakes: a pass runs once the buffer is empty after this cycle's beat
    assign take      = slot_vld_reg[0] && m_tready;
    assign room      = !slot_vld_reg[0] || (take && !slot_vld_reg[1]);
    assign fire      = in_vld_reg && room;
    assign s_tready  = !in_vld_reg || fire;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            park_period_reg  <= RST_PARK_PERIOD;
            brake_period_reg <= RST_BRAKE_PERIOD;
            accel_period_reg <= RST_ACCEL_PERIOD;
            repeat_limit_reg <= RST_REPEAT_LIMIT;
            ack_id_reg       <= RST_FRAME_ID;
            park_id_reg      <= RST_FRAME_ID;
            brake_id_reg     <= RST_FRAME_ID;
            accel_id_reg     <= RST_FRAME_ID;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_PARK_PERIOD:  park_period_reg  <= cfg_data;
                REG_BRAKE_PERIOD: brake_period_reg <= cfg_data;
                REG_ACCEL_PERIOD: accel_period_reg <= cfg_data;
                REG_PARK_REPEAT:  repeat_limit_reg <= cfg_data[REPEAT_W-1:0];
                REG_PARK_ACK_ID:  ack_id_reg       <= cfg_data[FRAME_ID_W-1:0];
                REG_PARK_ID:      park_id_reg      <= cfg_data[FRAME_ID_W-1:0];
                REG_BRAKE_ID:     brake_id_reg     <= cfg_data[FRAME_ID_W-1:0];
                REG_ACCEL_ID:     accel_id_reg     <= cfg_data[FRAME_ID_W-1:0];
                default: ;
            endcase
        end
    end

    // Tick, acknowledge, level changes and sample latch
    always_comb begin
        pt_mid    = tick ? sat_inc(park_timer_reg)  : park_timer_reg;
        bt_mid    = tick ? sat_inc(brake_timer_reg) : brake_timer_reg;
        at_mid    = tick ? sat_inc(accel_timer_reg) : accel_timer_reg;
        ack       = rx_valid && (rx_id == ack_id_reg)
                    && (rx_byte == BYTE_W'(park_state_reg));
        park_chg  = park_level != park_state_reg;
        brake_chg = brake_level != brake_state_reg;
        rep_mid   = ack ? '0 : repeats_reg;
        if (park_chg) begin
            rep_mid = repeat_limit_reg;
            pt_mid  = sat_inc(park_period_reg);
        end
        if (brake_chg) begin
            bt_mid = sat_inc(brake_period_reg);
        end
        pos_mid = sample_valid ? sample : accel_pos_reg;
    end

    // Due messages, limited by free transmit buffers
    always_comb begin
        park_send  = (rep_mid != '0) && (pt_mid >= park_period_reg) && (tx_free != '0);
        brake_send = (bt_mid >= brake_period_reg) && (tx_free > FREE_W'(park_send));
        accel_send = (at_mid >= accel_period_reg)
                     && (tx_free > (FREE_W'(park_send) + FREE_W'(brake_send)));
    end

    // State update for the pass
    always_comb begin
        park_state_next  = park_state_reg;
        brake_state_next = brake_state_reg;
        accel_pos_next   = accel_pos_reg;
        repeats_next     = repeats_reg;
        park_timer_next  = park_timer_reg;
        brake_timer_next = brake_timer_reg;
        accel_timer_next = accel_timer_reg;
        if (fire) begin
            park_state_next  = park_level;
            brake_state_next = brake_level;
            accel_pos_next   = pos_mid;
            repeats_next     = park_send ? rep_mid - 1'b1 : rep_mid;
            park_timer_next  = park_send  ? '0 : pt_mid;
            brake_timer_next = brake_send ? '0 : bt_mid;
            accel_timer_next = accel_send ? '0 : at_mid;
        end
    end

    // Pack sent frames into consecutive slots and mark the last one
    always_comb begin
        logic [1:0] idx;
        idx     = '0;
        send[0] = park_send;
        send[1] = brake_send;
        send[2] = accel_send;
        cand[0] = '{frame_id: park_id_reg, frame_len: LEN_STATE,
                    frame_payload: POS_W'(park_level), last_frame: 1'b0};
        cand[1] = '{frame_id: brake_id_reg, frame_len: LEN_STATE,
                    frame_payload: POS_W'(brake_level), last_frame: 1'b0};
        cand[2] = '{frame_id: accel_id_reg, frame_len: LEN_ACCEL,
                    frame_payload: pos_mid, last_frame: 1'b0};
        for (int k = 0; k < 3; k++) begin
            new_vld[k]  = 1'b0;
            new_slot[k] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            if (send[i]) begin
                new_vld[idx]  = 1'b1;
                new_slot[idx] = cand[i];
                idx           = idx + 1'b1;
            end
        end
        new_slot[0].last_frame = new_vld[0] && !new_vld[1];
        new_slot[1].last_frame = new_vld[1] && !new_vld[2];
        new_slot[2].last_frame = new_vld[2];
    end

    // Frame buffer: shift on a taken beat, load on a pass
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            slot_vld_next[k] = slot_vld_reg[k];
            slot_next[k]     = slot_reg[k];
        end
        if (take) begin
            slot_vld_next[0] = slot_vld_reg[1];
            slot_vld_next[1] = slot_vld_reg[2];
            slot_vld_next[2] = 1'b0;
            slot_next[0]     = slot_reg[1];
            slot_next[1]     = slot_reg[2];
        end
        if (fire) begin
            for (int k = 0; k < 3; k++) begin
                slot_vld_next[k] = new_vld[k];
                slot_next[k]     = new_slot[k];
            end
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            park_state_reg  <= 1'b0;
            brake_state_reg <= 1'b0;
            accel_pos_reg   <= '0;
            repeats_reg     <= '0;
            park_timer_reg  <= '0;
            brake_timer_reg <= '0;
            accel_timer_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                slot_vld_reg[k] <= 1'b0;
            end
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            park_state_reg  <= park_state_next;
            brake_state_reg <= brake_state_next;
            accel_pos_reg   <= accel_pos_next;
            repeats_reg     <= repeats_next;
            park_timer_reg  <= park_timer_next;
            brake_timer_reg <= brake_timer_next;
            accel_timer_reg <= accel_timer_next;
            for (int k = 0; k < 3; k++) begin
                slot_vld_reg[k] <= slot_vld_next[k];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        for (int k = 0; k < 3; k++) begin
            slot_reg[k] <= slot_next[k];
        end
    end

    // Result beat
    assign m_tvalid = slot_vld_reg[0];
    assign m_tlast  = slot_reg[0].last_frame;
    assign m_tdata  = {1'b0, slot_reg[0].frame_payload, slot_reg[0].frame_len,
                       slot_reg[0].frame_id};

endmodule

`default_nettype wire

### hdl/psms_checker.sv
// Port-level checker for the pedal status message scheduler, with its bind.
// Depends on psms_pkg and pedal_status_message_scheduler_unit_assert.svh.
`default_nettype none

`include "pedal_status_message_scheduler_unit_assert.svh"

module psms_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    // frame_id, frame_len, frame_payload, zero pad
    input wire logic [psms_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic                             m_tlast
);
    import psms_pkg::*;

    // Stalled result beat holds
    `PSMS_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled frame changed")

    // Only state and accelerator lengths are sent
    `PSMS_ASSERT_IMP(a_len, aclk, aresetn, m_tvalid, (m_tdata[OUT_LEN_LSB +: LEN_W] == LEN_STATE) || (m_tdata[OUT_LEN_LSB +: LEN_W] == LEN_ACCEL), "bad frame length")

    // A state frame carries a single bit
    `PSMS_ASSERT_IMP(a_state_pay, aclk, aresetn, m_tvalid && (m_tdata[OUT_LEN_LSB +: LEN_W] == LEN_STATE), m_tdata[OUT_PAY_LSB+1 +: POS_W-1] == '0, "state payload wider than one bit")

    // Pad bit stays zero
    `PSMS_ASSERT_IMP(a_pad, aclk, aresetn, m_tvalid, !m_tdata[OUT_TDATA_W-1], "nonzero pad bit")

endmodule

bind pedal_status_message_scheduler_unit psms_checker u_psms_checker (.*);

`default_nettype wire
